// ----- design/linear_interp_resampler_defines.svh -----
// Assertion macros shared by the resampler RTL.
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LIR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

// ----- design/lir_pkg.sv -----
// Shared types and constants of the linear interpolation resampler.
package lir_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned STEP_W     = 19;
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE = 2'd2;

  // Register reset values.
  localparam logic [STEP_W-1:0] STEP_RESET = 19'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;  // take the input word, shift samples, drop one phase unit
    logic eval;     // form interpolation numerators, advance phase and count
    logic scale;    // multiply numerators by gain
    logic sat;      // shift, saturate, mute into the output register
  } lir_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic run_ok;   // phase below one unit and output cap not reached
    logic last;     // the output being formed ends the run
  } lir_sts_t;

endpackage

// ----- design/lir_stream_if.sv -----
// Valid/ready stream interfaces for source samples and output samples.
interface lir_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [15:0]         in_left;
  logic signed [15:0]         in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface lir_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [15:0]         out_left;
  logic signed [15:0]         out_right;
  logic                       last_of_run;

  modport source (output valid, output out_left, output out_right, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_left, input out_right, input last_of_run,
                  output ready);
endinterface

// ----- design/linear_interp_resampler.sv -----
// Top level of the stereo linear interpolation sample rate converter.
//
//  channel  dir  handshake        word
//  in_i     in   valid/ready      in_left, in_right (signed 16)
//  out_o    out  valid/ready      out_left, out_right (signed 16), last_of_run
//  cfg      in   cfg_we_i only    cfg_idx_i selects step_ratio, gain, mute_enable
//
// An input word is taken in the idle state; the evaluate state then finds whether it
// makes any output. Each output it makes steps through evaluate, scale, saturate and
// present, and the block takes no new word before the last of them is taken.
// These steps are set by the two registered multiplies per output feeding one
// output register. Reset is asynchronous, active low; it loads the register
// defaults and a phase of one unit. A stalled output holds its word and the
// block takes no input until the run of outputs is drained.
`include "linear_interp_resampler_defines.svh"

module linear_interp_resampler import lir_pkg::*; #(
  parameter int unsigned PHASE_FRAC_BITS       = 16,
  parameter int unsigned MAX_OUTPUTS_PER_INPUT = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lir_in_if.sink                in_i,
  lir_out_if.source             out_o
);

  lir_cmd_t cmd;
  lir_sts_t sts;

  // Sequence the per-word and per-output steps.
  lir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Hold config, samples and phase; interpolate, scale and saturate.
  lir_dp #(
    .PHASE_FRAC_BITS       (PHASE_FRAC_BITS),
    .MAX_OUTPUTS_PER_INPUT (MAX_OUTPUTS_PER_INPUT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_left_i   (in_i.in_left),
    .in_right_i  (in_i.in_right),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_left_o  (out_o.out_left),
    .out_right_o (out_o.out_right),
    .last_o      (out_o.last_of_run)
  );

  // One word in flight: never take input while an output is shown.
  `LIR_ASSERT_IMPLY(a_no_overlap, out_o.valid, !in_i.ready)
  // After taking an input word, work on it before taking another.
  `LIR_ASSERT_NEXT(a_busy_after_take, in_i.valid && in_i.ready, !in_i.ready)
  // The last output of a run returns the block to taking input.
  `LIR_ASSERT_NEXT(a_last_frees_input,
                   out_o.valid && out_o.ready && out_o.last_of_run, in_i.ready)

endmodule

// ----- design/lir_ctrl.sv -----
// Sequencer of the resampler: input take, per-output evaluate/scale/saturate/emit.
module lir_ctrl import lir_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lir_cmd_t cmd_o,
  input  lir_sts_t sts_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_SAT   = 5'b01000,
    ST_OUT   = 5'b10000
  } lir_state_e;

  lir_state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.run_ok) begin
          cmd_o.eval = 1'b1;
          state_d    = ST_SCALE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = sts_i.last ? ST_IDLE : ST_EVAL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/lir_dp.sv -----
// Datapath of the resampler: config, sample history, phase, interpolation and scaling.
module lir_dp import lir_pkg::*; #(
  parameter int unsigned PHASE_FRAC_BITS       = 16,
  parameter int unsigned MAX_OUTPUTS_PER_INPUT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic signed [SAMPLE_W-1:0]  in_left_i,
  input  logic signed [SAMPLE_W-1:0]  in_right_i,
  input  lir_cmd_t                    cmd_i,
  output lir_sts_t                    sts_o,
  output logic signed [SAMPLE_W-1:0]  out_left_o,
  output logic signed [SAMPLE_W-1:0]  out_right_o,
  output logic                        last_o
);

  localparam int unsigned PW   = PHASE_FRAC_BITS + 3;
  localparam int unsigned SUMW = ((PW > STEP_W) ? PW : STEP_W) + 1;
  localparam int unsigned CW   = $clog2(MAX_OUTPUTS_PER_INPUT + 1);
  localparam int unsigned NW   = PHASE_FRAC_BITS + 18;
  localparam int unsigned VW   = NW + GAIN_W + 1;
  localparam int unsigned SH   = PHASE_FRAC_BITS + 8;
  localparam int unsigned MW   = VW - SH;

  localparam logic [PW-1:0]   PHASE_ONE = {3'b001, {PHASE_FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0]   PHASE_MAX = '1;
  localparam logic [CW-1:0]   CNT_MAX   = CW'(MAX_OUTPUTS_PER_INPUT);

  // a * 2^F + (b - a) * p, exact.
  function automatic logic signed [NW-1:0] interp_num(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [PHASE_FRAC_BITS-1:0] p
  );
    logic signed [NW-1:0]            a_sh;
    logic signed [SAMPLE_W:0]        d;
    logic signed [PHASE_FRAC_BITS:0] ps;
    logic signed [NW-1:0]            dp;
    a_sh = {{2{a[SAMPLE_W-1]}}, a, {PHASE_FRAC_BITS{1'b0}}};
    d    = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
    ps   = {1'b0, p};
    dp   = d * ps;
    return a_sh + dp;
  endfunction

  // Drop the Q(F+8) fraction toward zero, then clamp to signed 16 bits.
  function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [VW-1:0] v);
    logic [VW-1:0] negv;
    logic [MW-1:0] mag;
    logic [MW-1:0] neg;
    negv = '0;
    neg  = '0;
    if (v[VW-1]) begin
      negv = VW'(0) - v;
      mag  = negv[VW-1:SH];
      if (mag > MW'(32768)) begin
        mag = MW'(32768);
      end
      neg = MW'(0) - mag;
      return neg[SAMPLE_W-1:0];
    end else begin
      mag = v[VW-1:SH];
      if (mag > MW'(32767)) begin
        mag = MW'(32767);
      end
      return mag[SAMPLE_W-1:0];
    end
  endfunction

  logic [STEP_W-1:0]          step_q;
  logic [GAIN_W-1:0]          gain_q;
  logic                       mute_q;
  logic signed [SAMPLE_W-1:0] older_l_q, older_r_q, newer_l_q, newer_r_q;
  logic [PW-1:0]              phase_q, phase_d;
  logic [CW-1:0]              count_q, count_inc;
  logic                       last_q, last_d;
  logic signed [NW-1:0]       num_l_q, num_r_q;
  logic signed [VW-1:0]       prod_l_q, prod_r_q;
  logic signed [SAMPLE_W-1:0] out_l_q, out_r_q;
  logic [SUMW-1:0]            phase_sum;
  logic signed [GAIN_W:0]     gain_s;

  assign phase_sum = SUMW'(phase_q) + SUMW'(step_q);
  assign phase_d   = (phase_sum > SUMW'(PHASE_MAX)) ? PHASE_MAX : phase_sum[PW-1:0];
  assign count_inc = count_q + CW'(1);
  assign last_d    = (phase_d >= PHASE_ONE) || (count_inc == CNT_MAX);
  assign gain_s    = {1'b0, gain_q};

  assign sts_o.run_ok = (phase_q < PHASE_ONE) && (count_q < CNT_MAX);
  assign sts_o.last   = last_q;

  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      gain_q <= GAIN_RESET;
      mute_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP: step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_GAIN: gain_q <= cfg_wdata_i[GAIN_W-1:0];
        CFG_MUTE: mute_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_l_q <= '0;
      older_r_q <= '0;
      newer_l_q <= '0;
      newer_r_q <= '0;
      phase_q   <= PHASE_ONE;
      count_q   <= '0;
      last_q    <= 1'b0;
    end else if (cmd_i.load_in) begin
      older_l_q <= newer_l_q;
      older_r_q <= newer_r_q;
      newer_l_q <= in_left_i;
      newer_r_q <= in_right_i;
      phase_q   <= (phase_q >= PHASE_ONE) ? (phase_q - PHASE_ONE) : '0;
      count_q   <= '0;
    end else if (cmd_i.eval) begin
      phase_q <= phase_d;
      count_q <= count_inc;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      num_l_q <= interp_num(older_l_q, newer_l_q, phase_q[PHASE_FRAC_BITS-1:0]);
      num_r_q <= interp_num(older_r_q, newer_r_q, phase_q[PHASE_FRAC_BITS-1:0]);
    end
    if (cmd_i.scale) begin
      prod_l_q <= num_l_q * gain_s;
      prod_r_q <= num_r_q * gain_s;
    end
    if (cmd_i.sat) begin
      out_l_q <= mute_q ? '0 : sat16(prod_l_q);
      out_r_q <= mute_q ? '0 : sat16(prod_r_q);
    end
  end

endmodule
